// ===== hdl/lrp_pkg.sv =====
// Package for the range-to-point converter: field widths, codes and the
// quarter-wave sine table generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

  localparam int RANGE_W     = 16;
  localparam int IDX_W       = 10;
  localparam int POSE_W      = 32;
  localparam int ANG_W       = 16;
  localparam int TRIG_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int ANGLE_BITS_DEF = 10;
  localparam int unsigned MAX_SAMPLES = 1024;

  localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 16'd3000;

  // pose store: a single entry holding {z, y, x}
  localparam int POSE_DEPTH = 1;
  localparam int POSE_AW    = (POSE_DEPTH > 1) ? $clog2(POSE_DEPTH) : 1;

  localparam logic MODE_POSE   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd2;

  localparam real PI_HALF = 1.5707963267948966;

  // round(32767 * sin(q * pi/2 / 2^(abits-2))), elaboration only
  function automatic int qtab_val(int q, int abits);
    real x;
    x = PI_HALF * q * (2.0 ** (2 - abits));
    return $rtoi(32767.0 * $sin(x) + 0.5);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lrp_if.sv =====
// Stream interfaces of the range-to-point converter: sample/pose input and
// point output. Depends on lrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrp_in_if;
  import lrp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [RANGE_W-1:0]        range_mm;
  logic [IDX_W-1:0]          sample_index;
  logic signed [POSE_W-1:0]  new_x;
  logic signed [POSE_W-1:0]  new_y;
  logic signed [POSE_W-1:0]  new_z;

  modport source (output valid, mode, range_mm, sample_index, new_x, new_y, new_z,
                  input ready);
  modport sink   (input valid, mode, range_mm, sample_index, new_x, new_y, new_z,
                  output ready);
endinterface

interface lrp_out_if;
  import lrp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POSE_W-1:0]  point_x;
  logic signed [POSE_W-1:0]  point_y;
  logic signed [POSE_W-1:0]  point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/lrp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrp_sincos.sv =====
// Sine/cosine lookup from a quarter-wave table, registered outputs.
// Depends on lrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrp_sincos #(
  parameter int ANGLE_BITS = lrp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [ANGLE_BITS-1:0]            k,
  output logic signed [lrp_pkg::TRIG_W-1:0]     sin_r,
  output logic signed [lrp_pkg::TRIG_W-1:0]     cos_r
);
  import lrp_pkg::*;

  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int QW      = ANGLE_BITS - 1;   // index 0..QUARTER

  logic signed [TRIG_W-1:0] qtab [QUARTER+1];

  for (genvar q = 0; q <= QUARTER; q++) begin : g_tab
    assign qtab[q] = TRIG_W'(qtab_val(q, ANGLE_BITS));
  end

  logic [ANGLE_BITS-1:0]    k_cos;
  logic [QW-1:0]            idx_s, idx_c;
  logic signed [TRIG_W-1:0] mag_s, mag_c;
  logic signed [TRIG_W-1:0] sin_nxt, cos_nxt;

  assign k_cos = k + ANGLE_BITS'(QUARTER);

  always_comb begin
    // odd quadrants mirror the quarter wave, upper half negates
    idx_s = k[ANGLE_BITS-2] ? (QW'(QUARTER) - {1'b0, k[ANGLE_BITS-3:0]})
                            : {1'b0, k[ANGLE_BITS-3:0]};
    idx_c = k_cos[ANGLE_BITS-2] ? (QW'(QUARTER) - {1'b0, k_cos[ANGLE_BITS-3:0]})
                                : {1'b0, k_cos[ANGLE_BITS-3:0]};
    mag_s = qtab[idx_s];
    mag_c = qtab[idx_c];
    sin_nxt = k[ANGLE_BITS-1]     ? -mag_s : mag_s;
    cos_nxt = k_cos[ANGLE_BITS-1] ? -mag_c : mag_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lidar_range_to_point.sv =====
// Range-to-point converter top level: pose store, angle, trig lookup,
// offset multiply and output register.
// Depends on lrp_pkg, lrp_if, lrp_ram, lrp_sincos.
`timescale 1ns / 1ps
`default_nettype none

// Sample item: from transfer to result in the output register it passes
//   IDLE (transfer/angle), TRIG (table lookup), MUL (range multiply) and
//   OUT (pose add); the next item is taken once the sequence is back in IDLE.
// Pose item and rejected samples: taken in IDLE, no result.
// A result waiting in the output register holds the last step only.
// Reset (rst_n low, synchronous): config to reset values, pose reads as zero
//   until first written, output empty. No clearing pass.

module lidar_range_to_point #(
  parameter int ANGLE_BITS = lrp_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lrp_in_if.sink                             in_ch,
  lrp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrp_pkg::CFG_W-1:0]     cfg_data
);
  import lrp_pkg::*;

  localparam int PW = 3 * POSE_W;
  localparam int PROD_W = RANGE_W + TRIG_W + 1;   // 17 x 16 signed
  localparam int OFF_W  = PROD_W - 15;            // after >>> 15

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRIG = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [RANGE_W-1:0] range_limit_r;
  logic [ANG_W-1:0]   angle_start_r;
  logic [ANG_W-1:0]   angle_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r <= RANGE_LIMIT_RST;
      angle_start_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LIMIT: range_limit_r <= cfg_data[RANGE_W-1:0];
        REG_ANGLE_START: angle_start_r <= cfg_data[ANG_W-1:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_data[ANG_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input transfer and sample qualification
  logic in_xfer;
  logic sample_ok;
  logic pose_we;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign sample_ok   = (in_ch.mode == MODE_SAMPLE)
                    && (32'(in_ch.sample_index) < 32'(MAX_SAMPLES))
                    && (in_ch.range_mm < range_limit_r);
  assign pose_we     = in_xfer && (in_ch.mode == MODE_POSE);

  // angle = start + index * step, wraps at a full turn; keep top bits only
  logic [IDX_W+ANG_W-1:0] ang_prod;
  logic [ANG_W-1:0]       angle;
  logic [ANGLE_BITS-1:0]  k_r;
  logic [RANGE_W-1:0]     range_r;

  assign ang_prod = (IDX_W+ANG_W)'(in_ch.sample_index) * (IDX_W+ANG_W)'(angle_step_r);
  assign angle    = angle_start_r + ang_prod[ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      k_r     <= angle[ANG_W-1 -: ANGLE_BITS];
      range_r <= in_ch.range_mm;
    end
  end

  // pose store; entry reads as zero until first pose transfer
  logic                pose_valid_r;
  logic [POSE_AW-1:0]  pose_addr;
  logic [PW-1:0]       pose_rdata;
  logic signed [POSE_W-1:0] pose_x, pose_y, pose_z;

  assign pose_addr = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_valid_r <= 1'b0;
    end else if (pose_we) begin
      pose_valid_r <= 1'b1;
    end
  end

  lrp_ram #(
    .WIDTH (PW),
    .DEPTH (POSE_DEPTH)
  ) u_pose_ram (
    .clk   (clk),
    .we    (pose_we),
    .waddr (pose_addr),
    .wdata ({in_ch.new_z, in_ch.new_y, in_ch.new_x}),
    .re    (in_xfer),
    .raddr (pose_addr),
    .rdata (pose_rdata)
  );

  // read data holds until the next transfer, so it is used directly later on
  assign pose_x = pose_valid_r ? pose_rdata[POSE_W-1:0]        : '0;
  assign pose_y = pose_valid_r ? pose_rdata[2*POSE_W-1:POSE_W] : '0;
  assign pose_z = pose_valid_r ? pose_rdata[PW-1:2*POSE_W]     : '0;

  // trig lookup, registered inside
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  lrp_sincos #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_sincos (
    .clk   (clk),
    .en    (state_r == ST_TRIG),
    .k     (k_r),
    .sin_r (sin_r),
    .cos_r (cos_r)
  );

  // range x trig, two multipliers side by side
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [RANGE_W:0]  range_s;

  assign range_s = signed'({1'b0, range_r});

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_x_r <= range_s * cos_r;
      prod_y_r <= range_s * sin_r;
    end
  end

  // floor division by 2^15 is the arithmetic shift; then wrap-around add
  logic signed [OFF_W-1:0]  off_x, off_y;
  logic signed [POSE_W-1:0] sum_x, sum_y;

  assign off_x = prod_x_r[PROD_W-1:15];
  assign off_y = prod_y_r[PROD_W-1:15];
  assign sum_x = pose_x + {{(POSE_W-OFF_W){off_x[OFF_W-1]}}, off_x};
  assign sum_y = pose_y + {{(POSE_W-OFF_W){off_y[OFF_W-1]}}, off_y};

  // output register: free when empty or being taken
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic out_load;
  logic signed [POSE_W-1:0] out_x_r, out_y_r, out_z_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_OUT) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= sum_x;
      out_y_r <= sum_y;
      out_z_r <= pose_z;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.point_x = out_x_r;
  assign out_ch.point_y = out_y_r;
  assign out_ch.point_z = out_z_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && sample_ok) state_nxt = ST_TRIG;
      end
      ST_TRIG: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && sample_ok) |=> (state_r == ST_TRIG))
    else $error("qualified sample did not start the sequence");

  a_pose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pose_we |-> (state_r == ST_IDLE))
    else $error("pose written while a sample is in flight");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result load did not raise output valid");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("output valid raised outside the final step");

endmodule

`default_nettype wire

// ===== tb/sv/tb_lidar_range_to_point.sv =====
// Self-checking testbench for lidar_range_to_point: drives pose and sample transfers,
// predicts each obstacle point from its own sine table and pose copy, and checks every result.
// Depends on lrp_pkg, lrp_if and the lidar_range_to_point RTL.
`timescale 1ns / 1ps

module tb_lidar_range_to_point;
  import lrp_pkg::*;

  localparam int ANGLE_BITS   = ANGLE_BITS_DEF;
  localparam int QUARTER      = 1 << (ANGLE_BITS - 2);
  localparam int DRAIN_CYCLES = 10;   // time for a sample in flight to finish, with margin
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off for the pressure test
  localparam int ITEMS_PER_PHASE = 256;

  // index 3 is not a register: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [POSE_W-1:0] POSE_MIN = 32'h8000_0000;
  localparam logic [POSE_W-1:0] POSE_MAX = 32'h7FFF_FFFF;

  localparam longint unsigned ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam longint unsigned HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef struct packed {
    logic                     mode;
    logic [RANGE_W-1:0]       range_mm;
    logic [IDX_W-1:0]         sample_index;
    logic signed [POSE_W-1:0] new_x;
    logic signed [POSE_W-1:0] new_y;
    logic signed [POSE_W-1:0] new_z;
  } scan_item_t;

  typedef struct packed {
    logic signed [POSE_W-1:0] x;
    logic signed [POSE_W-1:0] y;
    logic signed [POSE_W-1:0] z;
  } point_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lrp_in_if  in_ch ();
  lrp_out_if out_ch ();

  lidar_range_to_point #(
    .ANGLE_BITS(ANGLE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers, the pose and the sine table
  // ---------------------------------------------------------------------------
  logic [RANGE_W-1:0]       range_limit_q;
  logic [ANG_W-1:0]         angle_start_q;
  logic [ANG_W-1:0]         angle_step_q;
  logic signed [POSE_W-1:0] pose_x_q, pose_y_q, pose_z_q;
  int                       sine_quarter [0:QUARTER];

  point_t expected_points [$];
  int     errors;

  // idling controls, one per side; cleared for stretches of back-to-back traffic
  bit tx_idle;
  bit rx_idle;

  // pressure request: bumping hold_req makes the receiver stall, hold_len sets the length of the hold
  int hold_req;
  int hold_len;
  int hold_seen;
  int rx_hold;
  int rx_wait;

  // (a * b) >> 62, full 128-bit product
  function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Taylor series of sin (odd) or cos in Q62 for 0 <= x <= pi/4
  function automatic longint unsigned taylor_q62(longint unsigned x, bit odd);
    longint unsigned x2, term, sum, d;
    x2   = q62_mul(x, x);
    term = odd ? x : ONE_Q62;
    sum  = term;
    for (longint unsigned n = 1; n <= 14; n++) begin
      d    = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
      term = q62_mul(term, x2) / d;
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // quarter wave of round(32767 * sin); upper half of the quarter from cos for accuracy
  task automatic build_sine_quarter();
    longint unsigned x, s;
    for (int q = 0; q <= QUARTER; q++) begin
      if (2 * q <= QUARTER) begin
        x = q62_mul(HALF_PI_Q62, longint'(q) << (64 - ANGLE_BITS));
        s = taylor_q62(x, 1'b1);
      end else begin
        x = q62_mul(HALF_PI_Q62, longint'(QUARTER - q) << (64 - ANGLE_BITS));
        s = taylor_q62(x, 1'b0);
      end
      sine_quarter[q] = int'(((s >> 20) * 64'd32767 + (64'd1 << 41)) >> 42);
    end
  endtask

  function automatic int sine_at(int unsigned k);
    int unsigned quad, q;
    int v;
    quad = (k >> (ANGLE_BITS - 2)) & 3;
    q    = k & (QUARTER - 1);
    v    = quad[0] ? sine_quarter[QUARTER - q] : sine_quarter[q];
    return quad[1] ? -v : v;
  endfunction

  // base + floor(range * trig / 2^15), wrapping in 32 bits
  function automatic logic [POSE_W-1:0] offset_pose(logic [POSE_W-1:0] base,
                                                   logic [RANGE_W-1:0] rng, int trig);
    longint p;
    p = longint'(rng) * longint'(trig);
    p = p >>> 15;
    return base + p[31:0];
  endfunction

  // Applies one accepted transfer to the predictor; queues a point where one is due.
  task automatic track_transfer(input scan_item_t it);
    logic [31:0]      turn;
    logic [ANG_W-1:0] angle;
    int unsigned      k;
    point_t           pt;
    if (it.mode == MODE_POSE) begin
      pose_x_q = it.new_x;
      pose_y_q = it.new_y;
      pose_z_q = it.new_z;
    end else if (it.sample_index < MAX_SAMPLES && it.range_mm < range_limit_q) begin
      turn  = 32'(it.sample_index) * 32'(angle_step_q);
      angle = angle_start_q + turn[ANG_W-1:0];
      k     = 32'(angle >> (ANG_W - ANGLE_BITS));
      pt.x  = offset_pose(pose_x_q, it.range_mm,
                          sine_at((k + QUARTER) & ((1 << ANGLE_BITS) - 1)));
      pt.y  = offset_pose(pose_y_q, it.range_mm, sine_at(k));
      pt.z  = pose_z_q;
      expected_points = {expected_points, pt};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver ready and the checker
  // ---------------------------------------------------------------------------
  // Ready drops for a randomly drawn wait after each transfer when rx_idle is set,
  // and for a long stretch whenever a hold-off is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
      rx_hold      <= 0;
      hold_seen    <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      rx_hold      <= hold_len;
      out_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      out_ch.ready <= (rx_hold == 1);
    end else if (out_ch.valid && out_ch.ready) begin
      int w;
      w = rx_idle ? $urandom_range(0, 4) : 0;
      rx_wait      <= w;
      out_ch.ready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait      <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // every transfer on the result side is compared with the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point_x", out_ch.point_x, 32'd0);
      end else begin
        point_t want;
        want = expected_points.pop_front();
        if (out_ch.point_x !== want.x) report_mismatch("point_x", out_ch.point_x, want.x);
        if (out_ch.point_y !== want.y) report_mismatch("point_y", out_ch.point_y, want.y);
        if (out_ch.point_z !== want.z) report_mismatch("point_z", out_ch.point_z, want.z);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------
  // Offers one item and returns just after the edge that took it. Valid is only
  // lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send_item(input scan_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.range_mm     <= it.range_mm;
    in_ch.sample_index <= it.sample_index;
    in_ch.new_x        <= it.new_x;
    in_ch.new_y        <= it.new_y;
    in_ch.new_z        <= it.new_z;
    do @(posedge clk); while (!in_ch.ready);
    track_transfer(it);
  endtask

  task automatic send_pose(input logic [POSE_W-1:0] x, input logic [POSE_W-1:0] y,
                           input logic [POSE_W-1:0] z);
    scan_item_t it;
    it.mode         = MODE_POSE;
    it.range_mm     = 16'($urandom());     // ignored by a pose transfer
    it.sample_index = IDX_W'($urandom());
    it.new_x        = x;
    it.new_y        = y;
    it.new_z        = z;
    send_item(it);
  endtask

  task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic [IDX_W-1:0] idx);
    scan_item_t it;
    it.mode         = MODE_SAMPLE;
    it.range_mm     = rng;
    it.sample_index = idx;
    it.new_x        = $urandom();   // ignored by a sample transfer
    it.new_y        = $urandom();
    it.new_z        = $urandom();
    send_item(it);
  endtask

  // Input idle, every point delivered, and time for any silent sample to finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write per edge; cfg_we is lowered by the caller after a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_RANGE_LIMIT: range_limit_q = val;
      REG_ANGLE_START: angle_start_q = val;
      REG_ANGLE_STEP:  angle_step_q  = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] start,
                              input logic [CFG_W-1:0] step);
    wait_idle();
    write_reg(REG_RANGE_LIMIT, limit);
    write_reg(REG_ANGLE_START, start);
    write_reg(REG_ANGLE_STEP, step);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: limit 3000, angle fixed at zero, pose at the origin.
  task automatic test_reset_values();
    send_sample(16'd0, 10'd0);
    send_sample(16'd2999, 10'd1023);    // just below the limit
    send_sample(16'd3000, 10'd5);       // at the limit: no point
    send_sample(16'hFFFF, 10'd0);
  endtask

  // Pose extremes, wrapping sums and ignored fields on both kinds of transfer.
  task automatic test_pose_updates();
    send_pose(POSE_MIN, POSE_MAX, 32'hFFFF_FFFF);
    send_sample(16'd2999, 10'd0);       // x grows from the minimum
    program_regs(16'hFFFF, 16'd0, 16'h8000);
    send_pose(POSE_MAX, POSE_MIN, 32'd0);
    send_sample(16'hFFFE, 10'd0);       // cos 0: x wraps past the maximum
    send_sample(16'hFFFE, 10'd1);       // half turn: x pulls back, y at minimum
    send_pose(32'd0, 32'd0, 32'd0);
  endtask

  // Register extremes and the unused register index.
  task automatic test_register_extremes();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFE, 10'h3FF);
    send_sample(16'hFFFF, 10'h3FF);     // at the top limit: no point
    program_regs(16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 10'd0);          // limit zero lets nothing through
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;
    send_sample(16'd0, 10'd0);
    program_regs(16'd1, 16'd0, 16'd0);
    send_sample(16'd0, 10'd7);          // zero range still makes a point
  endtask

  // Quadrant boundaries of the table, one quarter turn per index.
  task automatic test_quadrants();
    program_regs(16'd5000, 16'd0, 16'h4000);
    send_pose(32'd1000, -32'sd1000, 32'd77);
    for (int i = 0; i < 5; i++) send_sample(16'd4999, IDX_W'(i));
  endtask

  // Receiver holds off while samples keep coming, so the block backs up.
  task automatic test_back_pressure();
    program_regs(16'hFFFF, 16'($urandom()), 16'($urandom()));
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_len = HOLD_CYCLES;
    hold_req = hold_req + 1;
    for (int i = 0; i < 12; i++) send_sample(16'($urandom_range(0, 65534)), IDX_W'($urandom()));
  endtask

  function automatic logic [POSE_W-1:0] pick_pose_value();
    case ($urandom_range(0, 7))
      0: return POSE_MIN;
      1: return POSE_MAX;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Phases of random traffic, each under its own register setting and idling mix.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] limit, start, step;
    int count;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin limit = 16'hFFFF;  start = 16'd0;      step = 16'd64;     end
        1: begin limit = 16'd3000;  start = 16'hFFFF;   step = 16'hFFFF;   end
        2: begin
          limit = 16'd0;
          start = 16'($urandom());
          step  = 16'($urandom());
        end
        3: begin limit = 16'hFFFF;  start = 16'($urandom()); step = 16'd1; end
        default: begin
          limit = 16'($urandom());
          start = 16'($urandom());
          step  = 16'($urandom());
        end
      endcase
      program_regs(limit, start, step);
      count = (limit == 0) ? 30 : ITEMS_PER_PHASE;
      for (int i = 0; i < count; i++) begin
        // halfway through, flip the idling so both busy and bursty stretches occur
        if (i == 0) begin
          tx_idle = phase[0];
          rx_idle = phase[1] | ~phase[0];
        end else if (i == count / 2) begin
          tx_idle = ~tx_idle;
          rx_idle = ~rx_idle;
        end
        if ($urandom_range(0, 3) == 0)
          send_pose(pick_pose_value(), pick_pose_value(), pick_pose_value());
        else if (limit != 0 && $urandom_range(0, 7) != 0)
          send_sample(16'($urandom_range(0, limit - 1)), IDX_W'($urandom()));
        else
          send_sample(16'($urandom()), IDX_W'($urandom()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_RANGE_LIMIT;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_POSE;
    in_ch.range_mm     = '0;
    in_ch.sample_index = '0;
    in_ch.new_x        = '0;
    in_ch.new_y        = '0;
    in_ch.new_z        = '0;
    errors             = 0;
    tx_idle            = 1'b1;
    rx_idle            = 1'b1;
    hold_req           = 0;
    hold_len           = 0;

    // predictor starts from the reset values
    range_limit_q = RANGE_LIMIT_RST;
    angle_start_q = '0;
    angle_step_q  = '0;
    pose_x_q      = '0;
    pose_y_q      = '0;
    pose_z_q      = '0;
    build_sine_quarter();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_pose_updates();
    test_register_extremes();
    test_quadrants();
    test_back_pressure();
    test_random_traffic();

    // drain, bounded so a lost point cannot hang the run
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_points.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_points.size() != 0)
      report_mismatch("points never produced", expected_points.size(), 32'd0);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog against a hung run
  initial begin
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
